// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CHK_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CHK_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/thnf_pkg.sv
// Types and constants of the two-hop neighbor finder.
`default_nettype none

package thnf_pkg;

	localparam int NODE_W   = 4;
	localparam int NODE_SPAN = 1 << NODE_W;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = 5;
	localparam logic [CNT_W-1:0] NODE_COUNT_RST = 5'd16;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD   = 2'd0,
		FN_QUERY = 2'd1,
		FN_CLEAR = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic {
		EMIT_STATUS = 1'b0,
		EMIT_PEND   = 1'b1
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		logic      rd_a;
		logic      rd_b;
		logic      wr_a;
		logic      wr_b;
		logic      clr_graph;
		logic      q_init;
		logic      clr_i;
		logic      mark_dir;
		logic      issue_t;
		logic      take_f;
		logic      issue_h;
		logic      hop;
		logic      emit;
		emit_sel_t emit_sel;
		status_t   status;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  valid_a;
		logic  valid_b;
		logic  full;
		logic  more_t;
		logic  more_f;
	} sts_t;

endpackage

`default_nettype wire

// File: src/two_hop_neighbor_finder_top.sv
// An add reads both degrees, checks that no list is full, then writes both lists;
// clear, bad index and unused code answer from decode. A query reads the list of t,
// then that of each neighbor f, through the one read port of the neighbor-list memory.
// One request at a time: the next is taken in the cycle of the final result.
// Results are one-cycle strobes; the receiver cannot stall them.
// Reset empties the graph and sets node_count to 16; list memory needs no clearing.
`default_nettype none
`include "assert_macros.svh"

module two_hop_neighbor_finder_top #(
	parameter int NODES      = 16,
	parameter int MAX_DEGREE = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [thnf_pkg::FUNC_W-1:0]     func,
	input  logic [thnf_pkg::NODE_W-1:0]     node_a,
	input  logic [thnf_pkg::NODE_W-1:0]     node_b,
	input  logic                            cfg_we,
	input  logic [thnf_pkg::CNT_W-1:0]      cfg_wdata,
	output logic                            strobe,
	output logic [thnf_pkg::STATUS_W-1:0]   status,
	output logic                            found,
	output logic [thnf_pkg::NODE_W-1:0]     node,
	output logic                            last
);
	import thnf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	thnf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	thnf_dp #(
		.NODES      (NODES),
		.MAX_DEGREE (MAX_DEGREE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (func),
		.node_a    (node_a),
		.node_b    (node_b),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.strobe    (strobe),
		.status    (status),
		.found     (found),
		.node      (node),
		.last      (last)
	);

	`CHK_NXT(a_accept_busy, start && !busy, busy, "request accepted but block not busy")
	`CHK_IMP(a_last_idle, strobe && last, !busy, "final result while still busy")
	`CHK_IMP(a_mid_busy, strobe && !last, busy, "intermediate result while idle")
	`CHK_IMP(a_found_ok, strobe && found, status == ST_OK, "found result with error status")
	`CHK_IMP(a_nofound_last, strobe && !found, last, "empty result not marked last")

endmodule

`default_nettype wire

// File: src/thnf_ctrl.sv
// Controller state machine of the two-hop neighbor finder.
`default_nettype none

module thnf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  thnf_pkg::sts_t  sts,
	output thnf_pkg::cmd_t  cmd
);
	import thnf_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_DEC     = 11'b000_0000_0010,
		S_ADD_B   = 11'b000_0000_0100,
		S_ADD_CHK = 11'b000_0000_1000,
		S_ADD_W1  = 11'b000_0001_0000,
		S_ADD_W2  = 11'b000_0010_0000,
		S_QD      = 11'b000_0100_0000,
		S_QF      = 11'b000_1000_0000,
		S_QF2     = 11'b001_0000_0000,
		S_QH      = 11'b010_0000_0000,
		S_FIN     = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_DEC;
				end
			end
			S_DEC: begin
				cmd.rd_a = 1'b1;
				unique case (sts.func)
					FN_ADD: begin
						if (sts.valid_a && sts.valid_b) begin
							state_nxt = S_ADD_B;
						end else begin
							cmd.emit   = 1'b1;
							cmd.status = ST_RANGE;
							state_nxt  = S_IDLE;
						end
					end
					FN_QUERY: begin
						if (sts.valid_a) begin
							cmd.q_init = 1'b1;
							cmd.clr_i  = 1'b1;
							state_nxt  = S_QD;
						end else begin
							cmd.emit   = 1'b1;
							cmd.status = ST_RANGE;
							state_nxt  = S_IDLE;
						end
					end
					FN_CLEAR: begin
						cmd.clr_graph = 1'b1;
						cmd.emit      = 1'b1;
						cmd.status    = ST_OK;
						state_nxt     = S_IDLE;
					end
					default: begin
						cmd.emit   = 1'b1;
						cmd.status = ST_OK;
						state_nxt  = S_IDLE;
					end
				endcase
			end
			S_ADD_B: begin
				cmd.rd_b  = 1'b1;
				state_nxt = S_ADD_CHK;
			end
			S_ADD_CHK: begin
				if (sts.full) begin
					cmd.emit   = 1'b1;
					cmd.status = ST_FULL;
					state_nxt  = S_IDLE;
				end else begin
					state_nxt = S_ADD_W1;
				end
			end
			S_ADD_W1: begin
				cmd.wr_a  = 1'b1;
				state_nxt = S_ADD_W2;
			end
			S_ADD_W2: begin
				cmd.wr_b   = 1'b1;
				cmd.emit   = 1'b1;
				cmd.status = ST_OK;
				state_nxt  = S_IDLE;
			end
			S_QD: begin
				cmd.mark_dir = 1'b1;
				if (sts.more_t) begin
					cmd.issue_t = 1'b1;
				end else begin
					cmd.clr_i = 1'b1;
					state_nxt = S_QF;
				end
			end
			S_QF: begin
				if (sts.more_t) begin
					cmd.issue_t = 1'b1;
					state_nxt   = S_QF2;
				end else begin
					state_nxt = S_FIN;
				end
			end
			S_QF2: begin
				cmd.take_f = 1'b1;
				state_nxt  = S_QH;
			end
			S_QH: begin
				cmd.hop = 1'b1;
				if (sts.more_f) begin
					cmd.issue_h = 1'b1;
				end else begin
					state_nxt = S_QF;
				end
			end
			S_FIN: begin
				cmd.emit     = 1'b1;
				cmd.emit_sel = EMIT_PEND;
				cmd.status   = ST_OK;
				state_nxt    = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/thnf_dp.sv
// Datapath of the two-hop neighbor finder: lists, degrees, marks and results.
`default_nettype none

module thnf_dp #(
	parameter int NODES      = 16,
	parameter int MAX_DEGREE = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [thnf_pkg::FUNC_W-1:0]     func,
	input  logic [thnf_pkg::NODE_W-1:0]     node_a,
	input  logic [thnf_pkg::NODE_W-1:0]     node_b,
	input  logic                            cfg_we,
	input  logic [thnf_pkg::CNT_W-1:0]      cfg_wdata,
	input  thnf_pkg::cmd_t                  cmd,
	output thnf_pkg::sts_t                  sts,
	output logic                            strobe,
	output logic [thnf_pkg::STATUS_W-1:0]   status,
	output logic                            found,
	output logic [thnf_pkg::NODE_W-1:0]     node,
	output logic                            last
);
	import thnf_pkg::*;

	localparam int ROWS  = (NODES < NODE_SPAN) ? NODES : NODE_SPAN;
	localparam int ROW_W = $clog2(ROWS);
	localparam int IW    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int DEG_W = $clog2(MAX_DEGREE + 1);
	localparam int AW    = ROW_W + IW;
	localparam int DEPTH = 1 << AW;
	localparam logic [DEG_W-1:0]  MAX_DEG = DEG_W'(MAX_DEGREE);
	localparam logic [NODE_W:0]   ROW_LIM = (NODE_W + 1)'(ROWS);

	func_t                   func_q;
	logic [NODE_W-1:0]       a_q;
	logic [NODE_W-1:0]       b_q;
	logic [CNT_W-1:0]        node_count_q;
	logic [DEG_W-1:0]        degree_q [ROWS];
	logic [DEG_W-1:0]        deg_a_q;
	logic [DEG_W-1:0]        deg_b_q;
	logic [DEG_W-1:0]        i_q;
	logic [DEG_W-1:0]        j_q;
	logic [NODE_W-1:0]       f_q;
	logic [NODE_SPAN-1:0]    dir_mark_q;
	logic [NODE_SPAN-1:0]    emit_mark_q;
	logic                    pend_valid_q;
	logic [NODE_W-1:0]       pend_node_q;
	logic                    rv_s1;
	logic [NODE_W-1:0]       rdata_s1;
	logic [NODE_W-1:0]       mem [DEPTH];

	logic                    strobe_q;
	logic [STATUS_W-1:0]     status_q;
	logic                    found_q;
	logic [NODE_W-1:0]       node_q;
	logic                    last_q;

	logic [ROW_W-1:0]        deg_idx;
	logic [DEG_W-1:0]        deg_rd;
	logic [DEG_W:0]          self_sum;
	logic                    hop_hit;
	logic                    mem_we;
	logic [AW-1:0]           waddr;
	logic [NODE_W-1:0]       wdata;
	logic [AW-1:0]           raddr;

	function automatic logic node_ok(input logic [NODE_W-1:0] x,
	                                 input logic [CNT_W-1:0] cnt);
		node_ok = ({1'b0, x} < cnt) && ({1'b0, x} < ROW_LIM);
	endfunction

	always_comb begin
		if (cmd.take_f) begin
			deg_idx = rdata_s1[ROW_W-1:0];
		end else if (cmd.rd_b || cmd.wr_b) begin
			deg_idx = b_q[ROW_W-1:0];
		end else begin
			deg_idx = a_q[ROW_W-1:0];
		end
	end

	assign deg_rd   = degree_q[deg_idx];
	assign self_sum = {1'b0, deg_a_q} + (DEG_W + 1)'(2);

	assign sts.func    = func_q;
	assign sts.valid_a = node_ok(a_q, node_count_q);
	assign sts.valid_b = node_ok(b_q, node_count_q);
	assign sts.full    = (a_q == b_q) ? (self_sum > {1'b0, MAX_DEG})
	                                  : ((deg_a_q >= MAX_DEG) || (deg_b_q >= MAX_DEG));
	assign sts.more_t  = (i_q < deg_a_q);
	assign sts.more_f  = (j_q < deg_b_q);

	assign hop_hit = cmd.hop && rv_s1 && (rdata_s1 != a_q)
	                 && !dir_mark_q[rdata_s1] && !emit_mark_q[rdata_s1];

	assign mem_we = cmd.wr_a || cmd.wr_b;
	assign waddr  = cmd.wr_a ? {a_q[ROW_W-1:0], deg_a_q[IW-1:0]}
	                         : {b_q[ROW_W-1:0], deg_rd[IW-1:0]};
	assign wdata  = cmd.wr_a ? b_q : a_q;
	assign raddr  = cmd.issue_t ? {a_q[ROW_W-1:0], i_q[IW-1:0]}
	                            : {f_q[ROW_W-1:0], j_q[IW-1:0]};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(func);
			a_q    <= node_a;
			b_q    <= node_b;
		end
		if (cmd.rd_a) begin
			deg_a_q <= deg_rd;
		end
		if (cmd.rd_b) begin
			deg_b_q <= deg_rd;
		end else if (cmd.take_f) begin
			deg_b_q <= deg_rd;
		end
		if (cmd.take_f) begin
			f_q <= rdata_s1;
		end
		if (hop_hit) begin
			pend_node_q <= rdata_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			for (int k = 0; k < ROWS; k++) begin
				degree_q[k] <= '0;
			end
			i_q          <= '0;
			j_q          <= '0;
			dir_mark_q   <= '0;
			emit_mark_q  <= '0;
			pend_valid_q <= 1'b0;
			rv_s1        <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (cmd.clr_graph) begin
				for (int k = 0; k < ROWS; k++) begin
					degree_q[k] <= '0;
				end
			end else if (cmd.wr_a) begin
				degree_q[a_q[ROW_W-1:0]] <= deg_a_q + DEG_W'(1);
			end else if (cmd.wr_b) begin
				degree_q[deg_idx] <= deg_rd + DEG_W'(1);
			end
			if (cmd.clr_i) begin
				i_q <= '0;
			end else if (cmd.issue_t) begin
				i_q <= i_q + DEG_W'(1);
			end
			if (cmd.take_f) begin
				j_q <= '0;
			end else if (cmd.issue_h) begin
				j_q <= j_q + DEG_W'(1);
			end
			rv_s1 <= cmd.issue_t || cmd.issue_h;
			if (cmd.q_init) begin
				dir_mark_q   <= '0;
				emit_mark_q  <= '0;
				pend_valid_q <= 1'b0;
			end else begin
				if (cmd.mark_dir && rv_s1) begin
					dir_mark_q[rdata_s1] <= 1'b1;
				end
				if (hop_hit) begin
					emit_mark_q[rdata_s1] <= 1'b1;
					pend_valid_q          <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit || (hop_hit && pend_valid_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique case (cmd.emit_sel)
				EMIT_STATUS: begin
					status_q <= cmd.status;
					found_q  <= 1'b0;
					node_q   <= '0;
					last_q   <= 1'b1;
				end
				EMIT_PEND: begin
					status_q <= ST_OK;
					found_q  <= pend_valid_q;
					node_q   <= pend_valid_q ? pend_node_q : '0;
					last_q   <= 1'b1;
				end
				default: begin
					status_q <= ST_OK;
					found_q  <= 1'b0;
					node_q   <= '0;
					last_q   <= 1'b1;
				end
			endcase
		end else if (hop_hit && pend_valid_q) begin
			status_q <= ST_OK;
			found_q  <= 1'b1;
			node_q   <= pend_node_q;
			last_q   <= 1'b0;
		end
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign found  = found_q;
	assign node   = node_q;
	assign last   = last_q;

endmodule

`default_nettype wire

// File: tb/two_hop_neighbor_finder_top_tb.sv
// Self-checking testbench: directed and random requests and node_count writes checked against a predictor.
module two_hop_neighbor_finder_top_tb;
	import thnf_pkg::*;

	localparam int NODES      = NODE_SPAN;
	localparam int MAX_DEG    = 16;
	localparam int IDLE_LIMIT = 4000;
	localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

	typedef struct {
		status_t           status;
		logic              found;
		logic [NODE_W-1:0] node;
		logic              last;
	} reply_t;

	class two_hop_board;
		logic [CNT_W-1:0]  node_count;
		int unsigned       degree [NODES];
		logic [NODE_W-1:0] adj [NODES][MAX_DEG];
		reply_t            replies_due [$];
		int unsigned       mismatches;
		int unsigned       checked;
		int unsigned       requests;

		function new();
			node_count = NODE_COUNT_RST;
			foreach (degree[i]) degree[i] = 0;
			mismatches = 0;
			checked = 0;
			requests = 0;
		endfunction

		function void set_node_count(logic [CNT_W-1:0] v);
			node_count = v;
		endfunction

		function bit in_range(logic [NODE_W-1:0] i);
			return i < node_count;
		endfunction

		function void push_reply(status_t st, logic fd, logic [NODE_W-1:0] nd, logic lst);
			reply_t r;
			r.status = st;
			r.found = fd;
			r.node = nd;
			r.last = lst;
			replies_due.push_back(r);
		endfunction

		function status_t link_nodes(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
			if (a == b) begin
				if (degree[a] + 2 > MAX_DEG) return ST_FULL;
			end else if (degree[a] >= MAX_DEG || degree[b] >= MAX_DEG) begin
				return ST_FULL;
			end
			adj[a][degree[a]] = b;
			degree[a]++;
			adj[b][degree[b]] = a;
			degree[b]++;
			return ST_OK;
		endfunction

		function void walk_two_hop(logic [NODE_W-1:0] t);
			logic [NODES-1:0]  direct;
			logic [NODES-1:0]  emitted;
			logic [NODE_W-1:0] f;
			logic [NODE_W-1:0] c;
			logic [NODE_W-1:0] hits [$];
			int unsigned       i;
			int unsigned       j;
			direct = '0;
			emitted = '0;
			for (i = 0; i < degree[t]; i++) direct[adj[t][i]] = 1'b1;
			for (i = 0; i < degree[t]; i++) begin
				f = adj[t][i];
				for (j = 0; j < degree[f]; j++) begin
					c = adj[f][j];
					if (c != t && !direct[c] && !emitted[c] && hits.size() < NODES - 1) begin
						emitted[c] = 1'b1;
						hits.push_back(c);
					end
				end
			end
			if (hits.size() == 0) begin
				push_reply(ST_OK, 1'b0, '0, 1'b1);
			end else begin
				for (i = 0; i < hits.size(); i++)
					push_reply(ST_OK, 1'b1, hits[i], i == hits.size() - 1);
			end
		endfunction

		function void note_request(logic [FUNC_W-1:0] fn, logic [NODE_W-1:0] a,
				logic [NODE_W-1:0] b);
			requests++;
			case (fn)
				FN_ADD: begin
					if (!in_range(a) || !in_range(b)) push_reply(ST_RANGE, 1'b0, '0, 1'b1);
					else push_reply(link_nodes(a, b), 1'b0, '0, 1'b1);
				end
				FN_QUERY: begin
					if (!in_range(a)) push_reply(ST_RANGE, 1'b0, '0, 1'b1);
					else walk_two_hop(a);
				end
				FN_CLEAR: begin
					foreach (degree[i]) degree[i] = 0;
					push_reply(ST_OK, 1'b0, '0, 1'b1);
				end
				default: begin
					push_reply(ST_OK, 1'b0, '0, 1'b1);
				end
			endcase
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
		endtask

		task check_reply(logic [STATUS_W-1:0] st, logic fd, logic [NODE_W-1:0] nd, logic lst);
			reply_t due;
			checked++;
			if (replies_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0d found %0b node %0d last %0b",
					st, fd, nd, lst));
				return;
			end
			due = replies_due.pop_front();
			if (st !== due.status || fd !== due.found || nd !== due.node || lst !== due.last)
				report_mismatch($sformatf(
					"got status %0d found %0b node %0d last %0b, want %0d %0b %0d %0b",
					st, fd, nd, lst, due.status, due.found, due.node, due.last));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [FUNC_W-1:0]   func = '0;
	logic [NODE_W-1:0]   node_a = '0;
	logic [NODE_W-1:0]   node_b = '0;
	logic                cfg_we = 1'b0;
	logic [CNT_W-1:0]    cfg_wdata = NODE_COUNT_RST;
	logic                strobe;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [NODE_W-1:0]   node;
	logic                last;

	two_hop_board board;
	bit           burst = 1'b0;
	int unsigned  count_writes = 0;

	two_hop_neighbor_finder_top #(
		.NODES(NODES),
		.MAX_DEGREE(MAX_DEG)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.node_a(node_a),
		.node_b(node_b),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.strobe(strobe),
		.status(status),
		.found(found),
		.node(node),
		.last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && strobe) board.check_reply(status, found, node, last);
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || strobe) quiet = 0;
			else quiet++;
		end
		$display("FAIL two_hop_neighbor_finder_top");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [NODE_W-1:0] pick_node();
		int hi;
		hi = (board.node_count > NODES) ? NODES : board.node_count;
		if (hi == 0 || $urandom_range(0, 9) == 0) return NODE_W'($urandom_range(0, NODES - 1));
		return NODE_W'($urandom_range(0, hi - 1));
	endfunction

	task automatic send_request(logic [FUNC_W-1:0] fn, logic [NODE_W-1:0] a,
			logic [NODE_W-1:0] b);
		int gap;
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= fn;
		node_a <= a;
		node_b <= b;
		do @(posedge clk); while (busy);
		board.note_request(fn, a, b);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.replies_due.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_node_count(logic [CNT_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_node_count(v);
		count_writes++;
	endtask

	task automatic directed_requests();
		int k;
		write_node_count(5'd16);
		send_request(FN_QUERY, 4'd0, 4'd9);
		send_request(FN_ADD, 4'd0, 4'd1);
		send_request(FN_ADD, 4'd1, 4'd2);
		send_request(FN_ADD, 4'd1, 4'd4);
		send_request(FN_ADD, 4'd0, 4'd5);
		send_request(FN_ADD, 4'd5, 4'd6);
		send_request(FN_ADD, 4'd6, 4'd0);
		send_request(FN_ADD, 4'd0, 4'd1);
		send_request(FN_QUERY, 4'd0, 4'd0);
		// fill one list with self edges up to one free slot
		send_request(FN_ADD, 4'd9, 4'd10);
		for (k = 0; k < 7; k++) send_request(FN_ADD, 4'd9, 4'd9);
		send_request(FN_ADD, 4'd9, 4'd9);
		send_request(FN_ADD, 4'd10, 4'd9);
		send_request(FN_ADD, 4'd11, 4'd9);
		send_request(FN_QUERY, 4'd9, 4'd15);
		send_request(FN_ADD, 4'd15, 4'd0);
		send_request(FN_QUERY, 4'd15, 4'd15);
		send_request(FN_SPARE, 4'd15, 4'd15);
		send_request(FN_CLEAR, 4'd15, 4'd15);
		send_request(FN_QUERY, 4'd0, 4'd0);
		send_request(FN_ADD, 4'd1, 4'd12);
		send_request(FN_ADD, 4'd12, 4'd13);
		write_node_count(5'd4);
		send_request(FN_QUERY, 4'd1, 4'd0);
		send_request(FN_ADD, 4'd2, 4'd5);
		send_request(FN_ADD, 4'd7, 4'd1);
		send_request(FN_QUERY, 4'd4, 4'd0);
		send_request(FN_ADD, 4'd3, 4'd2);
		write_node_count(5'd0);
		send_request(FN_QUERY, 4'd0, 4'd0);
		send_request(FN_ADD, 4'd0, 4'd0);
		write_node_count(5'd31);
		send_request(FN_QUERY, 4'd15, 4'd0);
	endtask

	task automatic random_phase(logic [CNT_W-1:0] count, int items);
		int k;
		int r;
		logic [FUNC_W-1:0] fn;
		write_node_count(count);
		burst = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 1) == 0) send_request(FN_CLEAR, pick_node(), pick_node());
		for (k = 0; k < items; k++) begin
			r = $urandom_range(0, 99);
			if (r < 58) fn = FN_ADD;
			else if (r < 93) fn = FN_QUERY;
			else if (r < 96) fn = FN_CLEAR;
			else fn = FN_SPARE;
			send_request(fn, pick_node(), pick_node());
		end
		burst = 1'b0;
	endtask

	initial begin : main
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_requests();
		random_phase(5'd16, 20);
		random_phase(5'd2, 16);
		random_phase(CNT_W'($urandom_range(3, 15)), 18);
		random_phase(5'd31, 20);
		random_phase(5'd1, 10);
		random_phase(CNT_W'($urandom_range(17, 30)), 20);
		random_phase(5'd0, 6);
		random_phase(CNT_W'($urandom_range(5, 16)), 20);
		drain();
		repeat (12) @(posedge clk);
		$display("covered %0d requests and %0d results over %0d node_count writes",
			board.requests, board.checked, count_writes);
		$display("%0d mismatching results", board.mismatches);
		if (board.mismatches == 0) begin
			$display("PASS two_hop_neighbor_finder_top");
		end else begin
			$display("FAIL two_hop_neighbor_finder_top");
		end
		$finish;
	end

endmodule
